@@ sv/i2cseq_pkg.sv @@
// shared types and constants for the i2c transaction sequencer
`timescale 1ns / 1ps

package i2cseq_pkg;

    // entries in the decoupling queue between front and back, power of two
    localparam int QUEUE_DEPTH = 2;

    // bus engine status codes, low three bits masked off
    localparam logic [7:0] ST_MASK         = 8'hF8;
    localparam logic [7:0] ST_START        = 8'h08;
    localparam logic [7:0] ST_MT_SLA_ACK   = 8'h18;
    localparam logic [7:0] ST_MT_SLA_NACK  = 8'h20;
    localparam logic [7:0] ST_MT_DATA_ACK  = 8'h28;
    localparam logic [7:0] ST_MT_DATA_NACK = 8'h30;
    localparam logic [7:0] ST_MR_SLA_NACK  = 8'h38;
    localparam logic [7:0] ST_MR_SLA_ACK   = 8'h40;
    localparam logic [7:0] ST_MR_DATA_ACK  = 8'h50;
    localparam logic [7:0] ST_MR_DATA_NACK = 8'h58;

    // input item kinds
    localparam logic [1:0] KIND_FILL   = 2'd0;
    localparam logic [1:0] KIND_START  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;
    localparam logic [1:0] KIND_POP    = 2'd3;

    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_ADDR_NACK  = 2'd1,
        ERR_DATA_NACK  = 2'd2,
        ERR_UNEXPECTED = 2'd3
    } seq_err_t;

    typedef enum logic [3:0] {
        OP_FILL,
        OP_START,
        OP_POP,
        OP_ST_START,
        OP_MT_ACK,
        OP_MR_SLA_ACK,
        OP_MR_DATA_ACK,
        OP_MR_DATA_NACK,
        OP_SLA_NACK,
        OP_DATA_NACK,
        OP_UNEXPECTED
    } seq_op_t;

    // decoded item handed from front to back
    typedef struct packed {
        seq_op_t    op;
        logic       fill_ok;
        logic       rnw;
        logic [7:0] address;
        logic [7:0] length;
        logic [6:0] index;
        logic [7:0] data;
    } seq_item_t;

    typedef struct packed {
        logic       send_start;
        logic       send_stop;
        logic       ack_next;
        logic       irq_enable;
        logic       bus_enable;
        logic       load_tx;
        logic [7:0] tx_byte;
        logic       busy;
        logic [1:0] error_code;
        logic [7:0] rx_count;
        logic [7:0] read_byte;
    } seq_result_t;

    // result waiting for buffer read data
    typedef struct packed {
        seq_result_t res;
        logic        use_tx_rd;
        logic        use_rx_rd;
    } seq_stage_t;

endpackage

@@ sv/i2c_master_transaction_sequencer.sv @@
// i2c transaction sequencer top level: stream ports around front, queue and back
// path: input transfer into the queue, then the stage, then the output register
// throughput: one item per cycle while m_tready is high; the back end issues one
// queued item per cycle into a stage that picks up the registered buffer read,
// then the output register
// reset: synchronous aresetn clears queue, flags, counters and valid bits
`timescale 1ns / 1ps

module i2c_master_transaction_sequencer #(
    parameter int BUFFER_DEPTH = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // read_not_write, address_byte, length, write_index, data_byte,
    // status_code, received_byte
    input  logic [47:0] s_tdata,
    // kind
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // send_start, send_stop, ack_next, irq_enable, bus_enable, load_tx,
    // tx_byte, busy_res, error_code, rx_count, read_byte, zero fill
    output logic [39:0] m_tdata
);

    i2cseq_pkg::seq_item_t   item;
    logic                    item_valid;
    logic                    item_pop;
    i2cseq_pkg::seq_result_t res;

    i2cseq_front #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .kind           (s_tuser),
        .read_not_write (s_tdata[0]),
        .address_byte   (s_tdata[8:1]),
        .length         (s_tdata[16:9]),
        .write_index    (s_tdata[23:17]),
        .data_byte      (s_tdata[31:24]),
        .status_code    (s_tdata[39:32]),
        .received_byte  (s_tdata[47:40]),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .item           (item),
        .item_valid     (item_valid),
        .item_pop       (item_pop)
    );

    i2cseq_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item         (item),
        .item_valid   (item_valid),
        .item_pop     (item_pop),
        .result       (res),
        .result_valid (m_tvalid),
        .result_ready (m_tready)
    );

    assign m_tdata = {7'd0, res.read_byte, res.rx_count, res.error_code, res.busy,
                      res.tx_byte, res.load_tx, res.bus_enable, res.irq_enable,
                      res.ack_next, res.send_stop, res.send_start};

endmodule

@@ sv/i2cseq_front.sv @@
// front end: decodes input items into sequencer operations
`timescale 1ns / 1ps

module i2cseq_front #(
    parameter int BUFFER_DEPTH = 128
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [1:0]            kind,
    input  logic                  read_not_write,
    input  logic [7:0]            address_byte,
    input  logic [7:0]            length,
    input  logic [6:0]            write_index,
    input  logic [7:0]            data_byte,
    input  logic [7:0]            status_code,
    input  logic [7:0]            received_byte,
    input  logic                  in_valid,
    output logic                  in_ready,
    output i2cseq_pkg::seq_item_t item,
    output logic                  item_valid,
    input  logic                  item_pop
);

    i2cseq_pkg::seq_item_t dec;
    logic [7:0]            st;
    logic                  push;

    always_comb begin
        st          = status_code & i2cseq_pkg::ST_MASK;
        dec         = '0;
        dec.fill_ok = ({1'b0, write_index} < 8'(BUFFER_DEPTH));
        dec.rnw     = read_not_write;
        dec.address = read_not_write ? (address_byte | 8'h01) : address_byte;
        dec.length  = (length > 8'(BUFFER_DEPTH)) ? 8'(BUFFER_DEPTH) : length;
        dec.index   = write_index;
        dec.data    = (kind == i2cseq_pkg::KIND_FILL) ? data_byte : received_byte;
        case (kind)
            i2cseq_pkg::KIND_FILL:  dec.op = i2cseq_pkg::OP_FILL;
            i2cseq_pkg::KIND_START: dec.op = i2cseq_pkg::OP_START;
            i2cseq_pkg::KIND_POP:   dec.op = i2cseq_pkg::OP_POP;
            default: begin
                case (st)
                    i2cseq_pkg::ST_START:        dec.op = i2cseq_pkg::OP_ST_START;
                    i2cseq_pkg::ST_MT_SLA_ACK:   dec.op = i2cseq_pkg::OP_MT_ACK;
                    i2cseq_pkg::ST_MT_DATA_ACK:  dec.op = i2cseq_pkg::OP_MT_ACK;
                    i2cseq_pkg::ST_MR_SLA_ACK:   dec.op = i2cseq_pkg::OP_MR_SLA_ACK;
                    i2cseq_pkg::ST_MR_DATA_ACK:  dec.op = i2cseq_pkg::OP_MR_DATA_ACK;
                    i2cseq_pkg::ST_MR_DATA_NACK: dec.op = i2cseq_pkg::OP_MR_DATA_NACK;
                    i2cseq_pkg::ST_MT_SLA_NACK:  dec.op = i2cseq_pkg::OP_SLA_NACK;
                    i2cseq_pkg::ST_MR_SLA_NACK:  dec.op = i2cseq_pkg::OP_SLA_NACK;
                    i2cseq_pkg::ST_MT_DATA_NACK: dec.op = i2cseq_pkg::OP_DATA_NACK;
                    default:                     dec.op = i2cseq_pkg::OP_UNEXPECTED;
                endcase
            end
        endcase
    end

    assign push = in_valid && in_ready;

    i2cseq_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (dec),
        .not_full  (in_ready),
        .head      (item),
        .not_empty (item_valid),
        .pop       (item_pop)
    );

endmodule

@@ sv/i2cseq_queue.sv @@
// short fifo of decoded items between front and back
`timescale 1ns / 1ps

module i2cseq_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  i2cseq_pkg::seq_item_t push_item,
    output logic                  not_full,
    output i2cseq_pkg::seq_item_t head,
    output logic                  not_empty,
    input  logic                  pop
);

    localparam int PW = (i2cseq_pkg::QUEUE_DEPTH > 1) ? $clog2(i2cseq_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(i2cseq_pkg::QUEUE_DEPTH + 1);

    i2cseq_pkg::seq_item_t entry_reg [i2cseq_pkg::QUEUE_DEPTH];
    logic [PW-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  full;

    assign full      = (count_reg == CW'(i2cseq_pkg::QUEUE_DEPTH));
    assign not_full  = !full;
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ sv/i2cseq_back.sv @@
// back end: transaction state, buffers and result output register
`timescale 1ns / 1ps

module i2cseq_back #(
    parameter int BUFFER_DEPTH = 128
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  i2cseq_pkg::seq_item_t   item,
    input  logic                    item_valid,
    output logic                    item_pop,
    output i2cseq_pkg::seq_result_t result,
    output logic                    result_valid,
    input  logic                    result_ready
);

    localparam int AW = (BUFFER_DEPTH > 2) ? $clog2(BUFFER_DEPTH) : 1;

    logic [7:0] tx_mem [BUFFER_DEPTH];
    logic [7:0] rx_mem [BUFFER_DEPTH];
    logic [7:0] tx_rdata_reg;
    logic [7:0] rx_rdata_reg;

    logic [7:0]           tx_pos_reg, tx_pos_next;
    logic [7:0]           rx_fill_reg, rx_fill_next;
    logic [7:0]           len_reg, len_next;
    logic [7:0]           target_reg, target_next;
    logic                 busy_reg, busy_next;
    i2cseq_pkg::seq_err_t err_reg, err_next;

    i2cseq_pkg::seq_stage_t  stage_reg, stage_next;
    logic                    stage_valid_reg;
    i2cseq_pkg::seq_result_t out_reg, out_next;
    logic                    out_valid_reg;

    logic          stage_move;
    logic          tx_we, rx_we, tx_re, rx_re;
    logic [AW-1:0] tx_waddr, rx_waddr, tx_raddr, rx_raddr;
    logic [7:0]    idx_ext;
    logic          rx_room;
    logic [7:0]    fill_after;

    assign stage_move = stage_valid_reg && (!out_valid_reg || result_ready);
    assign item_pop   = item_valid && (!stage_valid_reg || stage_move);

    always_comb begin
        tx_pos_next  = tx_pos_reg;
        rx_fill_next = rx_fill_reg;
        len_next     = len_reg;
        target_next  = target_reg;
        busy_next    = busy_reg;
        err_next     = err_reg;
        stage_next   = '0;
        tx_we        = 1'b0;
        rx_we        = 1'b0;
        tx_re        = 1'b0;
        rx_re        = 1'b0;
        idx_ext      = {1'b0, item.index};
        tx_waddr     = idx_ext[AW-1:0];
        rx_waddr     = rx_fill_reg[AW-1:0];
        tx_raddr     = tx_pos_reg[AW-1:0];
        rx_room      = (rx_fill_reg < 8'(BUFFER_DEPTH));
        fill_after   = rx_room ? rx_fill_reg + 8'd1 : rx_fill_reg;

        if (item_pop) begin
            case (item.op)
                i2cseq_pkg::OP_FILL: begin
                    tx_we = !busy_reg && item.fill_ok;
                end
                i2cseq_pkg::OP_START: begin
                    if (!busy_reg) begin
                        err_next    = i2cseq_pkg::ERR_NONE;
                        len_next    = item.length;
                        target_next = item.address;
                        if (item.rnw) begin
                            rx_fill_next = '0;
                        end else begin
                            tx_pos_next = '0;
                        end
                        busy_next                   = 1'b1;
                        stage_next.res.send_start = 1'b1;
                        stage_next.res.irq_enable = 1'b1;
                        stage_next.res.bus_enable = 1'b1;
                    end
                end
                i2cseq_pkg::OP_POP: begin
                    if (rx_fill_reg != '0) begin
                        rx_fill_next         = rx_fill_reg - 8'd1;
                        rx_re                = 1'b1;
                        stage_next.use_rx_rd = 1'b1;
                    end
                end
                i2cseq_pkg::OP_ST_START: begin
                    stage_next.res.irq_enable = 1'b1;
                    stage_next.res.bus_enable = 1'b1;
                    stage_next.res.load_tx    = 1'b1;
                    stage_next.res.tx_byte    = target_reg;
                end
                i2cseq_pkg::OP_MT_ACK: begin
                    // stop once the whole write has gone out
                    if (tx_pos_reg >= len_reg) begin
                        stage_next.res.send_stop  = 1'b1;
                        stage_next.res.bus_enable = 1'b1;
                        busy_next                 = 1'b0;
                    end else begin
                        stage_next.res.irq_enable = 1'b1;
                        stage_next.res.bus_enable = 1'b1;
                        stage_next.res.load_tx    = 1'b1;
                        stage_next.use_tx_rd      = 1'b1;
                        tx_re                     = 1'b1;
                        tx_pos_next               = tx_pos_reg + 8'd1;
                    end
                end
                i2cseq_pkg::OP_MR_SLA_ACK: begin
                    stage_next.res.ack_next   = (len_reg > 8'd1);
                    stage_next.res.irq_enable = 1'b1;
                    stage_next.res.bus_enable = 1'b1;
                end
                i2cseq_pkg::OP_MR_DATA_ACK: begin
                    rx_we                     = rx_room;
                    rx_fill_next              = fill_after;
                    stage_next.res.ack_next   =
                        !(({1'b0, fill_after} + 9'd1) >= {1'b0, len_reg});
                    stage_next.res.irq_enable = 1'b1;
                    stage_next.res.bus_enable = 1'b1;
                end
                i2cseq_pkg::OP_MR_DATA_NACK: begin
                    rx_we                     = rx_room;
                    rx_fill_next              = fill_after;
                    stage_next.res.send_stop  = 1'b1;
                    stage_next.res.bus_enable = 1'b1;
                    busy_next                 = 1'b0;
                end
                i2cseq_pkg::OP_SLA_NACK: begin
                    err_next                  = i2cseq_pkg::ERR_ADDR_NACK;
                    stage_next.res.send_stop  = 1'b1;
                    stage_next.res.bus_enable = 1'b1;
                    busy_next                 = 1'b0;
                end
                i2cseq_pkg::OP_DATA_NACK: begin
                    err_next                  = i2cseq_pkg::ERR_DATA_NACK;
                    stage_next.res.send_stop  = 1'b1;
                    stage_next.res.bus_enable = 1'b1;
                    busy_next                 = 1'b0;
                end
                default: begin
                    err_next                 = i2cseq_pkg::ERR_UNEXPECTED;
                    stage_next.res.send_stop = 1'b1;
                    busy_next                = 1'b0;
                end
            endcase
        end

        rx_raddr                  = rx_fill_next[AW-1:0];
        stage_next.res.busy       = busy_next;
        stage_next.res.error_code = err_next;
        stage_next.res.rx_count   = rx_fill_next;

        // merge buffer read data into the finished result
        out_next = stage_reg.res;
        if (stage_reg.use_tx_rd) begin
            out_next.tx_byte = tx_rdata_reg;
        end
        if (stage_reg.use_rx_rd) begin
            out_next.read_byte = rx_rdata_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_pos_reg      <= '0;
            rx_fill_reg     <= '0;
            len_reg         <= '0;
            target_reg      <= '0;
            busy_reg        <= 1'b0;
            err_reg         <= i2cseq_pkg::ERR_NONE;
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            tx_pos_reg  <= tx_pos_next;
            rx_fill_reg <= rx_fill_next;
            len_reg     <= len_next;
            target_reg  <= target_next;
            busy_reg    <= busy_next;
            err_reg     <= err_next;
            if (item_pop) begin
                stage_valid_reg <= 1'b1;
            end else if (stage_move) begin
                stage_valid_reg <= 1'b0;
            end
            if (stage_move) begin
                out_valid_reg <= 1'b1;
            end else if (result_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (item_pop) begin
            stage_reg <= stage_next;
        end
        if (stage_move) begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (tx_we) begin
            tx_mem[tx_waddr] <= item.data;
        end
        if (tx_re) begin
            tx_rdata_reg <= tx_mem[tx_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (rx_we) begin
            rx_mem[rx_waddr] <= item.data;
        end
        if (rx_re) begin
            rx_rdata_reg <= rx_mem[rx_raddr];
        end
    end

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

endmodule

@@ bench/i2cseq_checker.sv @@
// response predictor and scoreboard for the i2c transaction sequencer streams
`timescale 1ns / 1ps

module i2cseq_checker #(
    parameter int DEPTH = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    output int          fail_count,
    output int          pending
);

    // mirrored sequencer state
    logic [7:0]           tx_mem [DEPTH];
    logic [7:0]           rx_mem [DEPTH];
    int unsigned          tx_pos;
    int unsigned          rx_held;
    int unsigned          xfer_len;
    logic [7:0]           target_addr;
    logic                 read_mode;
    logic                 busy;
    i2cseq_pkg::seq_err_t err_state;

    i2cseq_pkg::seq_result_t response_q[$];
    i2cseq_pkg::seq_result_t got;
    i2cseq_pkg::seq_result_t want;

    task automatic report(input string msg);
        fail_count++;
        if (fail_count <= 50) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endtask

    task automatic check_field(input string name, input int unsigned seen,
                               input int unsigned wanted);
        if (seen != wanted) begin
            report($sformatf("%s got 0x%0h expected 0x%0h", name, seen, wanted));
        end
    endtask

    function automatic void keep_rx_byte(input logic [7:0] b);
        if (rx_held < DEPTH) begin
            rx_mem[rx_held] = b;
            rx_held++;
        end
    endfunction

    // works out the engine commands and flags for one host transfer
    function automatic i2cseq_pkg::seq_result_t next_response(input logic [1:0] kind,
                                                              input logic [47:0] d);
        i2cseq_pkg::seq_result_t r;
        logic        rnw;
        logic [7:0]  addr;
        logic [7:0]  len_in;
        logic [6:0]  idx;
        logic [7:0]  data;
        logic [7:0]  status;
        logic [7:0]  rxb;
        int unsigned len;

        r      = '0;
        rnw    = d[0];
        addr   = d[8:1];
        len_in = d[16:9];
        idx    = d[23:17];
        data   = d[31:24];
        status = d[39:32];
        rxb    = d[47:40];

        case (kind)
            i2cseq_pkg::KIND_FILL: begin
                if (!busy && idx < DEPTH) begin
                    tx_mem[idx] = data;
                end
            end
            i2cseq_pkg::KIND_START: begin
                if (!busy) begin
                    len = (len_in > DEPTH) ? DEPTH : len_in;
                    err_state = i2cseq_pkg::ERR_NONE;
                    xfer_len = len;
                    if (rnw) begin
                        rx_held = 0;
                        target_addr = addr | 8'h01;
                        read_mode = 1'b1;
                    end else begin
                        tx_pos = 0;
                        target_addr = addr;
                        read_mode = 1'b0;
                    end
                    busy = 1'b1;
                    r.send_start = 1'b1;
                    r.irq_enable = 1'b1;
                    r.bus_enable = 1'b1;
                end
            end
            i2cseq_pkg::KIND_STATUS: begin
                case (status & i2cseq_pkg::ST_MASK)
                    i2cseq_pkg::ST_START: begin
                        r.irq_enable = 1'b1;
                        r.bus_enable = 1'b1;
                        r.load_tx    = 1'b1;
                        r.tx_byte    = target_addr;
                    end
                    i2cseq_pkg::ST_MT_SLA_ACK, i2cseq_pkg::ST_MT_DATA_ACK: begin
                        if (tx_pos >= xfer_len || tx_pos >= DEPTH) begin
                            r.send_stop  = 1'b1;
                            r.bus_enable = 1'b1;
                            busy = 1'b0;
                        end else begin
                            r.irq_enable = 1'b1;
                            r.bus_enable = 1'b1;
                            r.load_tx    = 1'b1;
                            r.tx_byte    = tx_mem[tx_pos];
                            tx_pos++;
                        end
                    end
                    i2cseq_pkg::ST_MR_SLA_ACK: begin
                        r.ack_next   = (xfer_len > 1);
                        r.irq_enable = 1'b1;
                        r.bus_enable = 1'b1;
                    end
                    i2cseq_pkg::ST_MR_DATA_ACK: begin
                        keep_rx_byte(rxb);
                        r.ack_next   = (rx_held + 1 >= xfer_len) ? 1'b0 : 1'b1;
                        r.irq_enable = 1'b1;
                        r.bus_enable = 1'b1;
                    end
                    i2cseq_pkg::ST_MR_DATA_NACK: begin
                        keep_rx_byte(rxb);
                        r.send_stop  = 1'b1;
                        r.bus_enable = 1'b1;
                        busy = 1'b0;
                    end
                    i2cseq_pkg::ST_MT_SLA_NACK, i2cseq_pkg::ST_MR_SLA_NACK: begin
                        err_state    = i2cseq_pkg::ERR_ADDR_NACK;
                        r.send_stop  = 1'b1;
                        r.bus_enable = 1'b1;
                        busy = 1'b0;
                    end
                    i2cseq_pkg::ST_MT_DATA_NACK: begin
                        err_state    = i2cseq_pkg::ERR_DATA_NACK;
                        r.send_stop  = 1'b1;
                        r.bus_enable = 1'b1;
                        busy = 1'b0;
                    end
                    default: begin
                        // engine is left disabled
                        err_state   = i2cseq_pkg::ERR_UNEXPECTED;
                        r.send_stop = 1'b1;
                        busy = 1'b0;
                    end
                endcase
            end
            default: begin
                // pop, last in first out
                if (rx_held > 0) begin
                    rx_held--;
                    if (rx_held < DEPTH) begin
                        r.read_byte = rx_mem[rx_held];
                    end
                end
            end
        endcase

        r.busy       = busy;
        r.error_code = err_state;
        r.rx_count   = 8'(rx_held);
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            tx_pos      = 0;
            rx_held     = 0;
            xfer_len    = 0;
            target_addr = 8'h00;
            read_mode   = 1'b1;
            busy        = 1'b0;
            err_state   = i2cseq_pkg::ERR_NONE;
            response_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.send_start = m_tdata[0];
                got.send_stop  = m_tdata[1];
                got.ack_next   = m_tdata[2];
                got.irq_enable = m_tdata[3];
                got.bus_enable = m_tdata[4];
                got.load_tx    = m_tdata[5];
                got.tx_byte    = m_tdata[13:6];
                got.busy       = m_tdata[14];
                got.error_code = m_tdata[16:15];
                got.rx_count   = m_tdata[24:17];
                got.read_byte  = m_tdata[32:25];
                if (response_q.size() == 0) begin
                    report($sformatf("result transfer 0x%0h with nothing expected",
                                     m_tdata));
                end else begin
                    want = response_q.pop_front();
                    check_field("send_start", got.send_start, want.send_start);
                    check_field("send_stop", got.send_stop, want.send_stop);
                    check_field("ack_next", got.ack_next, want.ack_next);
                    check_field("irq_enable", got.irq_enable, want.irq_enable);
                    check_field("bus_enable", got.bus_enable, want.bus_enable);
                    check_field("load_tx", got.load_tx, want.load_tx);
                    check_field("tx_byte", got.tx_byte, want.tx_byte);
                    check_field("busy_res", got.busy, want.busy);
                    check_field("error_code", got.error_code, want.error_code);
                    check_field("rx_count", got.rx_count, want.rx_count);
                    check_field("read_byte", got.read_byte, want.read_byte);
                end
            end
            if (s_tvalid && s_tready) begin
                response_q.push_back(next_response(s_tuser, s_tdata));
            end
        end
        pending <= response_q.size();
    end

endmodule

@@ bench/tb_i2c_master_transaction_sequencer.sv @@
// stimulus, stall generation and verdict for the i2c transaction sequencer
`timescale 1ns / 1ps

module tb_i2c_master_transaction_sequencer;

    localparam int DEPTH       = 128;
    localparam int TOTAL_ITEMS = 1300;
    localparam int QUIET_TAIL  = 150;
    localparam int STALL_LIMIT = 1000;

    // host item, last declared field in the lowest bits
    typedef struct packed {
        logic [7:0] received_byte;
        logic [7:0] status_code;
        logic [7:0] data_byte;
        logic [6:0] write_index;
        logic [7:0] length;
        logic [7:0] address_byte;
        logic       read_not_write;
    } host_item_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = i2cseq_pkg::KIND_FILL;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    int fail_count;
    int pending;
    int items_sent;
    int idle_cycles;
    int host_gap_odds;
    int sink_stall_odds = 2;
    int stall_left;
    bit quiet;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    i2c_master_transaction_sequencer #(
        .BUFFER_DEPTH(DEPTH)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    i2cseq_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // result side back-pressure in bursts of random length
    always @(posedge aclk) begin
        if (quiet || !aresetn) begin
            m_tready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 15) < sink_stall_odds) begin
            stall_left <= $urandom_range(0, 15);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
        if ($urandom_range(0, 199) == 0) begin
            sink_stall_odds <= $urandom_range(0, 4);
        end
    end

    // no transfer on either side for too long ends the run
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic host_item_t rand_fields();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return host_item_t'(r[47:0]);
    endfunction

    task automatic send_item(input logic [1:0] kind, input host_item_t f);
        if (!quiet && host_gap_odds != 0 && $urandom_range(0, 7) < host_gap_odds) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= f;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic do_fill(input logic [6:0] idx, input logic [7:0] data);
        host_item_t f;
        f = rand_fields();
        f.write_index = idx;
        f.data_byte = data;
        send_item(i2cseq_pkg::KIND_FILL, f);
    endtask

    task automatic do_start(input logic rnw, input logic [7:0] addr, input logic [7:0] len);
        host_item_t f;
        f = rand_fields();
        f.read_not_write = rnw;
        f.address_byte = addr;
        f.length = len;
        send_item(i2cseq_pkg::KIND_START, f);
    endtask

    // low three status bits are don't-care, so they get random values
    task automatic do_status(input logic [7:0] code, input logic [7:0] rxb);
        host_item_t f;
        f = rand_fields();
        f.status_code = code | 8'($urandom_range(0, 7));
        f.received_byte = rxb;
        send_item(i2cseq_pkg::KIND_STATUS, f);
    endtask

    task automatic do_pop();
        send_item(i2cseq_pkg::KIND_POP, rand_fields());
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        logic [7:0] known_codes [10];
        int         len;
        int         sel;
        int         n;
        bit         overflow_done;
        host_item_t f;

        known_codes = '{i2cseq_pkg::ST_START, i2cseq_pkg::ST_MT_SLA_ACK,
                        i2cseq_pkg::ST_MT_SLA_NACK, i2cseq_pkg::ST_MT_DATA_ACK,
                        i2cseq_pkg::ST_MT_DATA_NACK, i2cseq_pkg::ST_MR_SLA_NACK,
                        i2cseq_pkg::ST_MR_SLA_ACK, i2cseq_pkg::ST_MR_DATA_ACK,
                        i2cseq_pkg::ST_MR_DATA_NACK, 8'h00};
        overflow_done = 1'b0;
        host_gap_odds = 2;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // every transmit slot gets a byte before any write transaction
        for (int i = 0; i < DEPTH; i++) begin
            do_fill(7'(i), 8'($urandom_range(0, 255)));
        end

        // zero length write stops right after the address ack
        do_start(1'b0, 8'hA4, 8'd0);
        do_status(i2cseq_pkg::ST_START, 8'h00);
        do_status(i2cseq_pkg::ST_MT_SLA_ACK, 8'h00);
        // write with a start and a fill while busy, both ignored
        do_start(1'b0, 8'hFF, 8'd2);
        do_start(1'b1, 8'h12, 8'd5);
        do_fill(7'd0, 8'h5A);
        do_status(i2cseq_pkg::ST_START, 8'h00);
        do_status(i2cseq_pkg::ST_MT_SLA_ACK, 8'h00);
        do_status(i2cseq_pkg::ST_MT_DATA_ACK, 8'h00);
        do_status(i2cseq_pkg::ST_MT_DATA_ACK, 8'h00);
        // one byte read, address bit0 forced high
        do_start(1'b1, 8'h00, 8'd1);
        do_status(i2cseq_pkg::ST_MR_SLA_ACK, 8'h00);
        do_status(i2cseq_pkg::ST_MR_DATA_NACK, 8'hFF);
        // length clamp and address nack
        do_start(1'b1, 8'hFE, 8'd255);
        do_status(i2cseq_pkg::ST_MR_SLA_NACK, 8'h00);
        do_pop();
        do_pop();
        // data nack on a write
        do_start(1'b0, 8'h00, 8'd3);
        do_status(i2cseq_pkg::ST_START, 8'h00);
        do_status(i2cseq_pkg::ST_MT_SLA_ACK, 8'h00);
        do_status(i2cseq_pkg::ST_MT_DATA_NACK, 8'h00);
        // unexpected codes, then a receive status while idle
        do_status(8'h00, 8'h00);
        do_status(8'hFF, 8'h00);
        do_status(i2cseq_pkg::ST_MR_DATA_NACK, 8'h81);

        drain();

        while (items_sent < TOTAL_ITEMS) begin
            quiet = (items_sent >= TOTAL_ITEMS - QUIET_TAIL);
            host_gap_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
            sel = $urandom_range(0, 99);
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) :
                                                 $urandom_range(0, 6);

            if (!overflow_done && items_sent > 300) begin
                // more received bytes than the buffer holds
                overflow_done = 1'b1;
                do_start(1'b1, 8'($urandom_range(0, 255)), 8'd255);
                do_status(i2cseq_pkg::ST_START, 8'h00);
                do_status(i2cseq_pkg::ST_MR_SLA_ACK, 8'h00);
                for (int i = 0; i < DEPTH + 3; i++) begin
                    do_status(i2cseq_pkg::ST_MR_DATA_ACK, 8'($urandom_range(0, 255)));
                end
                do_status(i2cseq_pkg::ST_MR_DATA_NACK, 8'($urandom_range(0, 255)));
                repeat (4) do_pop();
            end else if (sel < 35) begin
                n = $urandom_range(0, 3);
                repeat (n) do_fill(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)));
                do_start(1'b0, 8'($urandom_range(0, 255)), 8'(len));
                do_status(i2cseq_pkg::ST_START, 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 9) == 0) begin
                    do_status(i2cseq_pkg::ST_MT_SLA_NACK, 8'($urandom_range(0, 255)));
                end else begin
                    do_status(i2cseq_pkg::ST_MT_SLA_ACK, 8'($urandom_range(0, 255)));
                    for (int i = 0; i < ((len > DEPTH) ? DEPTH : len); i++) begin
                        if ($urandom_range(0, 14) == 0) begin
                            do_status(i2cseq_pkg::ST_MT_DATA_NACK,
                                      8'($urandom_range(0, 255)));
                            break;
                        end
                        do_status(i2cseq_pkg::ST_MT_DATA_ACK, 8'($urandom_range(0, 255)));
                    end
                end
            end else if (sel < 75) begin
                do_start(1'b1, 8'($urandom_range(0, 255)), 8'(len));
                do_status(i2cseq_pkg::ST_START, 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 9) == 0) begin
                    do_status(i2cseq_pkg::ST_MR_SLA_NACK, 8'($urandom_range(0, 255)));
                end else begin
                    do_status(i2cseq_pkg::ST_MR_SLA_ACK, 8'($urandom_range(0, 255)));
                    for (int i = 1; i < ((len > DEPTH) ? DEPTH : len); i++) begin
                        do_status(i2cseq_pkg::ST_MR_DATA_ACK, 8'($urandom_range(0, 255)));
                    end
                    do_status(i2cseq_pkg::ST_MR_DATA_NACK, 8'($urandom_range(0, 255)));
                end
                n = $urandom_range(0, (len < 6) ? len + 1 : 6);
                repeat (n) do_pop();
            end else begin
                // broken sequences and stray transfers
                n = $urandom_range(1, 4);
                repeat (n) begin
                    f = rand_fields();
                    if ($urandom_range(0, 1) == 0) begin
                        f.status_code = known_codes[$urandom_range(0, 9)] |
                                        8'($urandom_range(0, 7));
                    end
                    send_item(2'($urandom_range(0, 3)), f);
                end
            end

            if ($urandom_range(0, 24) == 0) begin
                drain();
            end
        end

        quiet = 1'b1;
        drain();
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
